[hdl/aoc_pkg.sv]
// ----------------------------------------------------------------------------
// aoc_pkg
// Shared constants, types and arithmetic helpers for the ARGB source-over
// compositing pipeline.
// ----------------------------------------------------------------------------
package aoc_pkg;

	localparam int unsigned CH_W     = 8;
	localparam int unsigned PIX_W    = 32;
	localparam int unsigned NUM_CH   = 3;
	localparam int unsigned WGT_W    = 2 * CH_W;
	localparam int unsigned PROD_W   = 3 * CH_W;
	localparam int unsigned QUOT_W   = 17;
	localparam int unsigned NUM_W    = 18;

	localparam logic [CH_W-1:0]   ALPHA_MAX  = 8'hFF;
	localparam logic [CH_W-1:0]   ALPHA_ZERO = 8'h00;
	localparam logic [PROD_W-1:0] ROUND_HALF = 24'd127;
	// ceil(2^31 / 255), exact floor division for every 24-bit dividend
	localparam logic [PROD_W-1:0] RECIP_255  = 24'h808081;
	localparam int unsigned       RECIP_SH   = 31;

	// partial quotient and remainder of the per-channel restoring divider
	typedef struct packed {
		logic [CH_W-1:0]  quot;
		logic [NUM_W-1:0] rem;
	} div_t;

	// floor(x / 255) through a reciprocal multiply
	function automatic logic [QUOT_W-1:0] div255(input logic [PROD_W-1:0] x);
		logic [2*PROD_W-1:0] prod;
		prod = {{PROD_W{1'b0}}, x} * {{PROD_W{1'b0}}, RECIP_255};
		return prod[RECIP_SH +: QUOT_W];
	endfunction

	// two restoring divide steps, quotient bits hi and hi-1
	function automatic div_t div_pair(input div_t d, input logic [CH_W-1:0] oa,
		input int unsigned hi);
		div_t             r;
		logic [NUM_W-1:0] trial;
		r = d;
		for (int unsigned k = 0; k < 2; k++) begin
			trial = {{(NUM_W-CH_W){1'b0}}, oa} << (hi - k);
			if (r.rem >= trial) begin
				r.rem               = r.rem - trial;
				r.quot[hi - k]      = 1'b1;
			end
		end
		return r;
	endfunction

endpackage

[hdl/argb_alpha_over_composite.sv]
// ----------------------------------------------------------------------------
// argb_alpha_over_composite
// Source-over compositing of a straight-alpha ARGB8888 foreground pixel over
// a background pixel. Input channel: in_valid / in_stall with fore_pixel and
// back_pixel. Output channel: out_valid / out_stall with blended_pixel.
// Seven register stages: weights, products, output alpha and numerators,
// then four stages of a restoring divider that retires two quotient bits
// per stage for all three color channels in parallel. A request is registered
// in each stage in turn before out_valid rises; one request is accepted every
// cycle while in_stall is low.
// Each stage loads whenever it is empty or the stage behind it moves, so a
// stall on the output only backs up the input once every stage is full, and
// bubbles close up while the receiver stalls. Nothing is dropped or repeated.
// Reset clears the stage valid bits only; the pipeline comes up empty and
// ready to take a request in the first cycle after reset.
// ----------------------------------------------------------------------------
module argb_alpha_over_composite (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [aoc_pkg::PIX_W-1:0]   fore_pixel,
	input  logic [aoc_pkg::PIX_W-1:0]   back_pixel,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [aoc_pkg::PIX_W-1:0]   blended_pixel
);

	localparam int unsigned NS = 7;

	// stage valid bits and load enables
	logic [NS:1] vld_q;
	logic [NS:1] en;

	always_comb begin
		en[NS] = !vld_q[NS] || !out_stall;
		for (int i = NS - 1; i >= 1; i--) begin
			en[i] = !vld_q[i] || en[i+1];
		end
	end

	assign in_stall  = !en[1];
	assign out_valid = vld_q[NS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[1]) begin
				vld_q[1] <= in_valid;
			end
			for (int i = 2; i <= NS; i++) begin
				if (en[i]) begin
					vld_q[i] <= vld_q[i-1];
				end
			end
		end
	end

	// stage 1: split fields, background weight and foreground products
	logic                                               pass_s1;
	logic [aoc_pkg::PIX_W-1:0]                          pix_s1;
	logic [aoc_pkg::CH_W-1:0]                           fa_s1;
	logic [aoc_pkg::NUM_CH-1:0][aoc_pkg::CH_W-1:0]      bc_s1;
	logic [aoc_pkg::WGT_W-1:0]                          bw_s1;
	logic [aoc_pkg::NUM_CH-1:0][aoc_pkg::WGT_W-1:0]     ff_s1;
	logic [aoc_pkg::CH_W-1:0]                           fa_in;
	logic [aoc_pkg::CH_W-1:0]                           ba_in;

	assign fa_in = fore_pixel[31:24];
	assign ba_in = back_pixel[31:24];

	always_ff @(posedge clk) begin
		if (en[1]) begin
			pass_s1 <= (fa_in == aoc_pkg::ALPHA_ZERO) || (fa_in == aoc_pkg::ALPHA_MAX);
			pix_s1  <= (fa_in == aoc_pkg::ALPHA_ZERO) ? back_pixel : fore_pixel;
			fa_s1   <= fa_in;
			bw_s1   <= {{aoc_pkg::CH_W{1'b0}}, ba_in}
				* {{aoc_pkg::CH_W{1'b0}}, aoc_pkg::ALPHA_MAX - fa_in};
			for (int c = 0; c < aoc_pkg::NUM_CH; c++) begin
				bc_s1[c] <= back_pixel[c*aoc_pkg::CH_W +: aoc_pkg::CH_W];
				ff_s1[c] <= {{aoc_pkg::CH_W{1'b0}}, fore_pixel[c*aoc_pkg::CH_W +: aoc_pkg::CH_W]}
					* {{aoc_pkg::CH_W{1'b0}}, fa_in};
			end
		end
	end

	// stage 2: rounded alpha term and background products
	logic                                               pass_s2;
	logic [aoc_pkg::PIX_W-1:0]                          pix_s2;
	logic [aoc_pkg::CH_W-1:0]                           fa_s2;
	logic [aoc_pkg::CH_W-1:0]                           oaq_s2;
	logic [aoc_pkg::NUM_CH-1:0][aoc_pkg::WGT_W-1:0]     ff_s2;
	logic [aoc_pkg::NUM_CH-1:0][aoc_pkg::PROD_W-1:0]    bb_s2;
	logic [aoc_pkg::QUOT_W-1:0]                         oa_div;

	assign oa_div = aoc_pkg::div255({{aoc_pkg::CH_W{1'b0}}, bw_s1} + aoc_pkg::ROUND_HALF);

	always_ff @(posedge clk) begin
		if (en[2]) begin
			pass_s2 <= pass_s1;
			pix_s2  <= pix_s1;
			fa_s2   <= fa_s1;
			ff_s2   <= ff_s1;
			oaq_s2  <= oa_div[aoc_pkg::CH_W-1:0];
			for (int c = 0; c < aoc_pkg::NUM_CH; c++) begin
				bb_s2[c] <= {{aoc_pkg::WGT_W{1'b0}}, bc_s1[c]}
					* {{aoc_pkg::CH_W{1'b0}}, bw_s1};
			end
		end
	end

	// stage 3: output alpha with clamp, channel numerators
	logic                                               pass_s3;
	logic [aoc_pkg::PIX_W-1:0]                          pix_s3;
	logic [aoc_pkg::CH_W-1:0]                           oa_s3;
	logic [aoc_pkg::NUM_CH-1:0][aoc_pkg::NUM_W-1:0]     num_s3;
	logic [aoc_pkg::CH_W:0]                             oa_sum;
	logic [aoc_pkg::NUM_CH-1:0][aoc_pkg::NUM_W-1:0]     num_c;

	assign oa_sum = {1'b0, fa_s2} + {1'b0, oaq_s2};

	always_comb begin
		for (int c = 0; c < aoc_pkg::NUM_CH; c++) begin
			num_c[c] = {2'b00, ff_s2[c]} + {1'b0, aoc_pkg::div255(bb_s2[c])};
		end
	end

	always_ff @(posedge clk) begin
		if (en[3]) begin
			pass_s3 <= pass_s2;
			pix_s3  <= pix_s2;
			oa_s3   <= oa_sum[aoc_pkg::CH_W] ? aoc_pkg::ALPHA_MAX
				: oa_sum[aoc_pkg::CH_W-1:0];
			num_s3  <= num_c;
		end
	end

	// stage 4: overflow check and quotient bits 7 and 6
	logic                                               pass_s4;
	logic [aoc_pkg::PIX_W-1:0]                          pix_s4;
	logic [aoc_pkg::CH_W-1:0]                           oa_s4;
	logic [aoc_pkg::CH_W-1:0]                           oa_s5;
	logic [aoc_pkg::CH_W-1:0]                           oa_s6;
	logic [aoc_pkg::NUM_CH-1:0]                         ovf_s4;
	logic [aoc_pkg::NUM_CH-1:0]                         ovf_s5;
	logic [aoc_pkg::NUM_CH-1:0]                         ovf_s6;
	aoc_pkg::div_t [aoc_pkg::NUM_CH-1:0]                dv_s4;
	aoc_pkg::div_t [aoc_pkg::NUM_CH-1:0]                dv_s5;
	aoc_pkg::div_t [aoc_pkg::NUM_CH-1:0]                dv_s6;
	aoc_pkg::div_t [aoc_pkg::NUM_CH-1:0]                dv_c4;
	aoc_pkg::div_t [aoc_pkg::NUM_CH-1:0]                dv_c5;
	aoc_pkg::div_t [aoc_pkg::NUM_CH-1:0]                dv_c6;
	aoc_pkg::div_t [aoc_pkg::NUM_CH-1:0]                dv_c7;
	logic [aoc_pkg::NUM_CH-1:0]                         ovf_c;
	aoc_pkg::div_t                                      dv_init;

	always_comb begin
		dv_init = '0;
		for (int c = 0; c < aoc_pkg::NUM_CH; c++) begin
			ovf_c[c]     = num_s3[c] >= {2'b00, oa_s3, {aoc_pkg::CH_W{1'b0}}};
			dv_init.quot = '0;
			dv_init.rem  = num_s3[c];
			dv_c4[c]     = aoc_pkg::div_pair(dv_init, oa_s3, 7);
			dv_c5[c]     = aoc_pkg::div_pair(dv_s4[c], oa_s4, 5);
			dv_c6[c]     = aoc_pkg::div_pair(dv_s5[c], oa_s5, 3);
			dv_c7[c]     = aoc_pkg::div_pair(dv_s6[c], oa_s6, 1);
		end
	end

	always_ff @(posedge clk) begin
		if (en[4]) begin
			pass_s4 <= pass_s3;
			pix_s4  <= pix_s3;
			oa_s4   <= oa_s3;
			ovf_s4  <= ovf_c;
			dv_s4   <= dv_c4;
		end
	end

	// stage 5: quotient bits 5 and 4
	logic                                               pass_s5;
	logic [aoc_pkg::PIX_W-1:0]                          pix_s5;

	always_ff @(posedge clk) begin
		if (en[5]) begin
			pass_s5 <= pass_s4;
			pix_s5  <= pix_s4;
			oa_s5   <= oa_s4;
			ovf_s5  <= ovf_s4;
			dv_s5   <= dv_c5;
		end
	end

	// stage 6: quotient bits 3 and 2
	logic                                               pass_s6;
	logic [aoc_pkg::PIX_W-1:0]                          pix_s6;

	always_ff @(posedge clk) begin
		if (en[6]) begin
			pass_s6 <= pass_s5;
			pix_s6  <= pix_s5;
			oa_s6   <= oa_s5;
			ovf_s6  <= ovf_s5;
			dv_s6   <= dv_c6;
		end
	end

	// stage 7: last quotient bits, clamp and output register
	logic [aoc_pkg::PIX_W-1:0] blend_c;

	always_comb begin
		blend_c = {oa_s6, {(aoc_pkg::NUM_CH*aoc_pkg::CH_W){1'b0}}};
		for (int c = 0; c < aoc_pkg::NUM_CH; c++) begin
			blend_c[c*aoc_pkg::CH_W +: aoc_pkg::CH_W] = ovf_s6[c] ? aoc_pkg::ALPHA_MAX
				: dv_c7[c].quot;
		end
	end

	always_ff @(posedge clk) begin
		if (en[7]) begin
			blended_pixel <= pass_s6 ? pix_s6 : blend_c;
		end
	end

`ifndef ASSERT_OFF
	// input backs up only when every stage holds a request and the output stalls
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall && (&vld_q)))
		else $error("input stalled while the pipeline has room");

	// divisor of a blended request is never zero
	assert property (@(posedge clk) disable iff (!arst_n)
		(vld_q[4] && !pass_s4) |-> (oa_s4 != aoc_pkg::ALPHA_ZERO))
		else $error("zero output alpha reached the divider");

	// remainder after six quotient bits stays below four times the divisor
	assert property (@(posedge clk) disable iff (!arst_n)
		(vld_q[6] && !pass_s6 && !ovf_s6[0])
		|-> (dv_s6[0].rem < ({{(aoc_pkg::NUM_W-aoc_pkg::CH_W){1'b0}}, oa_s6} << 2)))
		else $error("divider remainder out of range");
`endif

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the source-over ARGB compositor. A directed table
// covers transparent, opaque and partial foregrounds at the extremes of alpha
// and color, then random pixel pairs run through three idle patterns. A
// long receiver hold fills the pipeline and backs up the input. Every result
// is checked in order against its table answer or a bit-exact integer prediction.
// ----------------------------------------------------------------------------
module testbench;

	localparam int unsigned CLK_HALF      = 5;
	localparam int unsigned RESET_CYCLES  = 10;
	localparam int unsigned NUM_DIRECTED  = 18;
	localparam int unsigned RANDOM_PER_PH = 444;
	localparam int unsigned HOLD_CYCLES   = 60;
	localparam int unsigned DRAIN_CYCLES  = 20;
	localparam int unsigned STALL_LIMIT   = 2000;
	localparam int unsigned MAX_REPORTS   = 50;
	localparam int unsigned CH_FULL       = 255;
	localparam int unsigned ROUND_BIAS    = 127;

	typedef logic [aoc_pkg::CH_W-1:0]  chan_t;
	typedef logic [aoc_pkg::PIX_W-1:0] pix_t;

	typedef enum logic [1:0] {
		PH_DIRECTED,
		PH_RECV_SLOW,
		PH_SEND_SLOW,
		PH_FULL_RATE
	} stim_phase_t;

	typedef struct packed {
		pix_t fore;
		pix_t back;
		logic typed;
		pix_t want;
	} dir_row_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	pix_t        fore_pixel;
	pix_t        back_pixel;
	logic        out_valid;
	logic        out_stall;
	pix_t        blended_pixel;

	// typed expectation riding along with the request on the input side
	logic        row_typed;
	pix_t        row_want;

	pix_t        pending_blends [$];
	stim_phase_t stim_phase;
	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;
	int unsigned error_count;
	int unsigned n_clear;
	int unsigned n_opaque;
	int unsigned n_partial;
	int unsigned n_checked;
	int unsigned n_backed_up;

	// transparent, opaque and easy partial rows carry their answer
	dir_row_t directed_rows [NUM_DIRECTED] = '{
		'{32'h00000000, 32'hFFFFFFFF, 1'b1, 32'hFFFFFFFF},
		'{32'h00ABCDEF, 32'h87654321, 1'b1, 32'h87654321},
		'{32'h00FFFFFF, 32'h00000000, 1'b1, 32'h00000000},
		'{32'hFFFFFFFF, 32'h00000000, 1'b1, 32'hFFFFFFFF},
		'{32'hFF000000, 32'h12345678, 1'b1, 32'hFF000000},
		'{32'hFF123456, 32'hFFFFFFFF, 1'b1, 32'hFF123456},
		'{32'h01ABCDEF, 32'h00FFFFFF, 1'b1, 32'h01ABCDEF},
		'{32'h80000000, 32'h00000000, 1'b1, 32'h80000000},
		'{32'hFEFFFFFF, 32'hFFFFFFFF, 1'b1, 32'hFFFFFFFF},
		'{32'hFE000000, 32'hFF000000, 1'b1, 32'hFF000000},
		'{32'h01FFFFFF, 32'hFFFFFFFF, 1'b0, 32'h00000000},
		'{32'h01000000, 32'hFFFFFFFF, 1'b0, 32'h00000000},
		'{32'h7FFFFFFF, 32'h80000000, 1'b0, 32'h00000000},
		'{32'h80FF00FF, 32'h7F00FF00, 1'b0, 32'h00000000},
		'{32'hFE00FF00, 32'h01FF00FF, 1'b0, 32'h00000000},
		'{32'h40C0C0C0, 32'hC0404040, 1'b0, 32'h00000000},
		'{32'h01FFFFFF, 32'h01000000, 1'b0, 32'h00000000},
		'{32'hFEFFFFFF, 32'h01FFFFFF, 1'b0, 32'h00000000}
	};

	argb_alpha_over_composite uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.fore_pixel    (fore_pixel),
		.back_pixel    (back_pixel),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.blended_pixel (blended_pixel)
	);

	// source-over of straight-alpha pixels, integer arithmetic
	function automatic pix_t composite_over(input pix_t fg, input pix_t bg);
		int unsigned fa;
		int unsigned ba;
		int unsigned bw;
		int unsigned oa;
		int unsigned num;
		int unsigned quo;
		pix_t        res;
		fa = fg[aoc_pkg::PIX_W-1 -: aoc_pkg::CH_W];
		ba = bg[aoc_pkg::PIX_W-1 -: aoc_pkg::CH_W];
		if (fa == aoc_pkg::ALPHA_ZERO)
			return bg;
		if (fa == aoc_pkg::ALPHA_MAX)
			return fg;
		bw = ba * (CH_FULL - fa);
		oa = fa + (bw + ROUND_BIAS) / CH_FULL;
		if (oa > CH_FULL)
			oa = CH_FULL;
		res = '0;
		res[aoc_pkg::PIX_W-1 -: aoc_pkg::CH_W] = oa[aoc_pkg::CH_W-1:0];
		for (int ch = 0; ch < aoc_pkg::NUM_CH; ch++) begin
			num = fg[ch*aoc_pkg::CH_W +: aoc_pkg::CH_W] * fa
				+ (bg[ch*aoc_pkg::CH_W +: aoc_pkg::CH_W] * bw) / CH_FULL;
			quo = num / oa;
			if (quo > CH_FULL)
				quo = CH_FULL;
			res[ch*aoc_pkg::CH_W +: aoc_pkg::CH_W] = quo[aoc_pkg::CH_W-1:0];
		end
		return res;
	endfunction

	function automatic chan_t pick_alpha();
		case ($urandom_range(9))
			0: return aoc_pkg::ALPHA_ZERO;
			1: return aoc_pkg::ALPHA_MAX;
			2: return chan_t'($urandom_range(3, 1));
			3: return chan_t'($urandom_range(254, 252));
			default: return chan_t'($urandom_range(255));
		endcase
	endfunction

	function automatic chan_t pick_color();
		case ($urandom_range(7))
			0: return 8'h00;
			1: return 8'hFF;
			default: return chan_t'($urandom_range(255));
		endcase
	endfunction

	task automatic report_mismatch(input string what, input pix_t got, input pix_t want);
		error_count++;
		if (error_count <= MAX_REPORTS)
			$display("%0t: %s: got %08h, want %08h", $realtime, what, got, want);
	endtask

	// present one request after a random gap and wait for it to be taken
	task automatic offer_pixels(input pix_t fg, input pix_t bg,
		input logic typed, input pix_t want);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid   <= 1'b1;
		fore_pixel <= fg;
		back_pixel <= bg;
		row_typed  <= typed;
		row_want   <= want;
		do
			@(posedge clk);
		while (!(in_valid && !in_stall));
		@(negedge clk);
	endtask

	// clock
	initial begin
		clk = 1'b0;
		forever begin
			#CLK_HALF clk = ~clk;
		end
	end

	// receiver: random stall, plus one long hold once full rate begins
	initial begin : receiver
		int unsigned hold_left;
		bit          pressure_done;
		hold_left     = 0;
		pressure_done = 1'b0;
		out_stall     = 1'b0;
		forever begin
			@(negedge clk);
			if (stim_phase == PH_FULL_RATE && !pressure_done) begin
				hold_left     = HOLD_CYCLES;
				pressure_done = 1'b1;
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= ($urandom_range(99) < recv_idle_pct);
			end
		end
	end

	// predict on input acceptance, check on output acceptance
	always @(posedge clk) begin : monitor
		pix_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (pending_blends.size() == 0) begin
					report_mismatch("unexpected blended_pixel", blended_pixel, '0);
				end else begin
					want = pending_blends.pop_front();
					n_checked++;
					if (blended_pixel !== want)
						report_mismatch("blended_pixel", blended_pixel, want);
				end
			end
			if (in_valid && in_stall)
				n_backed_up++;
			if (in_valid && !in_stall) begin
				if (fore_pixel[aoc_pkg::PIX_W-1 -: aoc_pkg::CH_W] == aoc_pkg::ALPHA_ZERO)
					n_clear++;
				else if (fore_pixel[aoc_pkg::PIX_W-1 -: aoc_pkg::CH_W] == aoc_pkg::ALPHA_MAX)
					n_opaque++;
				else
					n_partial++;
				pending_blends.push_back(row_typed ? row_want
					: composite_over(fore_pixel, back_pixel));
			end
		end
	end

	// watchdog on cycles with no handshake on either side
	initial begin : watchdog
		int unsigned quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("timeout: no handshake for %0d cycles", STALL_LIMIT);
		$display("argb_alpha_over_composite regression: fail");
		$finish;
	end

	// stimulus
	initial begin : stimulus
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		fore_pixel    = '0;
		back_pixel    = '0;
		row_typed     = 1'b0;
		row_want      = '0;
		stim_phase    = PH_DIRECTED;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		error_count   = 0;
		n_clear       = 0;
		n_opaque      = 0;
		n_partial     = 0;
		n_checked     = 0;
		n_backed_up   = 0;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed table
		for (int i = 0; i < NUM_DIRECTED; i++)
			offer_pixels(directed_rows[i].fore, directed_rows[i].back,
				directed_rows[i].typed, directed_rows[i].want);

		// random pairs under three idle patterns
		for (int ph = PH_RECV_SLOW; ph <= PH_FULL_RATE; ph++) begin
			stim_phase    = stim_phase_t'(ph);
			send_idle_pct = (ph == PH_RECV_SLOW) ? 26 : (ph == PH_SEND_SLOW) ? 71 : 0;
			recv_idle_pct = (ph == PH_RECV_SLOW) ? 71 : (ph == PH_SEND_SLOW) ? 26 : 0;
			for (int n = 0; n < RANDOM_PER_PH; n++)
				offer_pixels({pick_alpha(), pick_color(), pick_color(), pick_color()},
					{pick_alpha(), pick_color(), pick_color(), pick_color()},
					1'b0, '0);
		end
		in_valid <= 1'b0;

		// drain
		while (pending_blends.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d requests: %0d transparent, %0d opaque, %0d partial",
			n_clear + n_opaque + n_partial, n_clear, n_opaque, n_partial);
		$display("checked %0d results; input backed up for %0d cycles; %0d mismatches",
			n_checked, n_backed_up, error_count);
		if (error_count == 0)
			$display("argb_alpha_over_composite regression: pass");
		else
			$display("argb_alpha_over_composite regression: fail");
		$finish;
	end

endmodule
